[rtl/pfpm_pkg.sv]
// Shared types and constants of the page frame pool manager.
`timescale 1ns / 1ps
package pfpm_pkg;

  localparam int unsigned MaxFrames    = 512;
  localparam int unsigned IdxW         = $clog2(MaxFrames);
  localparam int unsigned LinkW        = IdxW + 1;
  localparam int unsigned CountW       = IdxW + 1;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned DefPageShift = 12;

  typedef logic [LinkW-1:0] link_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam link_t NIL = link_t'(MaxFrames);

  typedef enum logic [1:0] {
    MODE_REBUILD,
    MODE_ALLOC,
    MODE_FREE,
    MODE_EVICT
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_NO_BUSY,
    ST_NOT_BUSY
  } status_e;

  typedef enum logic [0:0] {
    CFG_POOL_START,
    CFG_POOL_END
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_APP1,
    S_APP2,
    S_RB_BASE,
    S_RB_COUNT,
    S_RB_SWEEP,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e      mode;
    logic [8:0] frame_index;
  } req_t;

  typedef struct packed {
    logic [8:0]       result_index;
    logic [AddrW-1:0] frame_addr;
    status_e          status;
    logic [9:0]       free_count;
  } rsp_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  nx_we;
    idx_t  nx_addr;
    link_t nx_data;
    logic  pv_we;
    idx_t  pv_addr;
    link_t pv_data;
    logic  bz_we;
    idx_t  bz_addr;
    logic  bz_data;
  } mem_cmd_t;

  typedef struct packed {
    link_t nx;
    link_t pv;
    logic  bz;
  } mem_rd_t;

endpackage

[rtl/pfpm_store.sv]
// Link and busy memories of the frame pool, one write and one registered read each.
`timescale 1ns / 1ps
module pfpm_store
  import pfpm_pkg::*;
(
  input  logic     clk_i,
  input  mem_cmd_t cmd_i,
  output mem_rd_t  rd_o
);

  link_t next_mem [MaxFrames];
  link_t prev_mem [MaxFrames];
  logic  busy_mem [MaxFrames];

  mem_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.nx_we) begin
      next_mem[cmd_i.nx_addr] <= cmd_i.nx_data;
    end
    if (cmd_i.pv_we) begin
      prev_mem[cmd_i.pv_addr] <= cmd_i.pv_data;
    end
    if (cmd_i.bz_we) begin
      busy_mem[cmd_i.bz_addr] <= cmd_i.bz_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q.nx <= next_mem[cmd_i.rd_addr];
      rd_q.pv <= prev_mem[cmd_i.rd_addr];
      rd_q.bz <= busy_mem[cmd_i.rd_addr];
    end
  end

  assign rd_o = rd_q;

endmodule

[rtl/pfpm_ctrl.sv]
// Sequencer for list heads and tails, link updates and the pool rebuild sweep.
`timescale 1ns / 1ps
module pfpm_ctrl
  import pfpm_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = DefPageShift
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_word_i,
  input  logic [AddrW-1:0] pool_start_i,
  input  logic [AddrW-1:0] pool_end_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output rsp_t             res_o,
  output mem_cmd_t         cmd_o,
  input  mem_rd_t          rd_i
);

  localparam logic [AddrW:0]   PageMask = (33'd1 << PAGE_SHIFT) - 33'd1;
  localparam logic [AddrW+1:0] PageSize = 34'd1 << PAGE_SHIFT;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  status_e          status_q, status_d;
  idx_t             f_q, f_d;
  link_t            fh_q, fh_d, ft_q, ft_d, bh_q, bh_d, bt_q, bt_d;
  link_t            tail_q, tail_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW:0]   rb_p_q, rb_p_d;
  idx_t             sweep_q, sweep_d;
  logic             built_q, built_d;

  link_t            app_tail;
  logic             is_busy;
  logic [AddrW:0]   rb_span;
  logic [AddrW:0]   rb_pages;
  link_t            sweep_next;

  assign app_tail = (mode_q == MODE_FREE) ? ft_q : bt_q;
  assign is_busy  = rd_i.bz & built_q;
  assign rb_span  = {1'b0, pool_end_i} - rb_p_q;
  assign rb_pages = rb_span >> PAGE_SHIFT;
  assign sweep_next = link_t'(sweep_q) + link_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fh_q    <= NIL;
      ft_q    <= NIL;
      bh_q    <= NIL;
      bt_q    <= NIL;
      total_q <= '0;
      base_q  <= '0;
      built_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      ft_q    <= ft_d;
      bh_q    <= bh_d;
      bt_q    <= bt_d;
      total_q <= total_d;
      base_q  <= base_d;
      built_q <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    status_q <= status_d;
    f_q      <= f_d;
    tail_q   <= tail_d;
    count_q  <= count_d;
    rb_p_q   <= rb_p_d;
    sweep_q  <= sweep_d;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    status_d    = status_q;
    f_d         = f_q;
    fh_d        = fh_q;
    ft_d        = ft_q;
    bh_d        = bh_q;
    bt_d        = bt_q;
    tail_d      = tail_q;
    total_d     = total_q;
    count_d     = count_q;
    base_d      = base_q;
    rb_p_d      = rb_p_q;
    sweep_d     = sweep_q;
    built_d     = built_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d   = in_word_i.mode;
          status_d = ST_OK;
          case (in_word_i.mode)
            MODE_ALLOC: f_d = fh_q[IdxW-1:0];
            MODE_EVICT: f_d = bh_q[IdxW-1:0];
            default:    f_d = idx_t'(in_word_i.frame_index);
          endcase
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = f_d;
          state_d = (in_word_i.mode == MODE_REBUILD) ? S_RB_BASE : S_LINK;
        end
      end

      S_LINK: begin
        state_d = S_APP1;
        case (mode_q)
          MODE_ALLOC: begin
            if (fh_q == NIL) begin
              status_d = ST_NO_FREE;
              state_d  = S_DONE;
            end else begin
              if (rd_i.pv == NIL) fh_d = rd_i.nx;
              if (rd_i.nx == NIL) ft_d = rd_i.pv;
              total_d       = total_q - CountW'(1);
              cmd_o.bz_we   = 1'b1;
              cmd_o.bz_data = 1'b1;
            end
          end
          MODE_EVICT: begin
            if (bh_q == NIL) begin
              status_d = ST_NO_BUSY;
              state_d  = S_DONE;
            end else if (bh_q == bt_q) begin
              state_d = S_DONE;
            end else begin
              if (rd_i.pv == NIL) bh_d = rd_i.nx;
              if (rd_i.nx == NIL) bt_d = rd_i.pv;
            end
          end
          default: begin
            if (!is_busy) begin
              status_d = ST_NOT_BUSY;
              state_d  = S_DONE;
            end else begin
              if (rd_i.pv == NIL) bh_d = rd_i.nx;
              if (rd_i.nx == NIL) bt_d = rd_i.pv;
              total_d       = total_q + CountW'(1);
              cmd_o.bz_we   = 1'b1;
              cmd_o.bz_data = 1'b0;
            end
          end
        endcase
        if (state_d == S_APP1) begin
          cmd_o.bz_addr = f_q;
          cmd_o.nx_we   = (rd_i.pv != NIL);
          cmd_o.nx_addr = rd_i.pv[IdxW-1:0];
          cmd_o.nx_data = rd_i.nx;
          cmd_o.pv_we   = (rd_i.nx != NIL);
          cmd_o.pv_addr = rd_i.nx[IdxW-1:0];
          cmd_o.pv_data = rd_i.pv;
        end
      end

      S_APP1: begin
        tail_d        = app_tail;
        cmd_o.pv_we   = 1'b1;
        cmd_o.pv_addr = f_q;
        cmd_o.pv_data = app_tail;
        cmd_o.nx_we   = 1'b1;
        cmd_o.nx_addr = f_q;
        cmd_o.nx_data = NIL;
        if (mode_q == MODE_FREE) begin
          if (ft_q == NIL) fh_d = link_t'(f_q);
          ft_d = link_t'(f_q);
        end else begin
          if (bt_q == NIL) bh_d = link_t'(f_q);
          bt_d = link_t'(f_q);
        end
        state_d = S_APP2;
      end

      S_APP2: begin
        cmd_o.nx_we   = (tail_q != NIL);
        cmd_o.nx_addr = tail_q[IdxW-1:0];
        cmd_o.nx_data = link_t'(f_q);
        state_d       = S_DONE;
      end

      S_RB_BASE: begin
        rb_p_d  = ({1'b0, pool_start_i} + PageMask) & ~PageMask;
        state_d = S_RB_COUNT;
      end

      S_RB_COUNT: begin
        if (({1'b0, rb_p_q} + PageSize) <= {2'b00, pool_end_i}) begin
          if (rb_pages > (AddrW + 1)'(MaxFrames)) begin
            count_d = CountW'(MaxFrames);
          end else begin
            count_d = rb_pages[CountW-1:0];
          end
        end else begin
          count_d = '0;
        end
        base_d  = rb_p_q[AddrW-1:0];
        built_d = 1'b1;
        total_d = count_d;
        fh_d    = (count_d != '0) ? link_t'(0) : NIL;
        ft_d    = (count_d != '0) ? link_t'(count_d - CountW'(1)) : NIL;
        bh_d    = NIL;
        bt_d    = NIL;
        f_d     = '0;
        sweep_d = '0;
        state_d = S_RB_SWEEP;
      end

      S_RB_SWEEP: begin
        cmd_o.bz_we   = 1'b1;
        cmd_o.bz_addr = sweep_q;
        cmd_o.bz_data = 1'b0;
        if (link_t'(sweep_q) < link_t'(count_q)) begin
          cmd_o.nx_we   = 1'b1;
          cmd_o.nx_addr = sweep_q;
          cmd_o.nx_data = (sweep_next == link_t'(count_q)) ? NIL : sweep_next;
          cmd_o.pv_we   = 1'b1;
          cmd_o.pv_addr = sweep_q;
          cmd_o.pv_data = (sweep_q == '0) ? NIL : link_t'(sweep_q) - link_t'(1);
        end
        sweep_d = sweep_q + idx_t'(1);
        if (sweep_q == '1) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o            = '0;
    res_o.status     = status_q;
    res_o.free_count = 10'(total_q);
    if (status_q != ST_NO_FREE && status_q != ST_NO_BUSY) begin
      res_o.result_index = 9'(f_q);
    end
    if (status_q == ST_OK && mode_q != MODE_REBUILD) begin
      res_o.frame_addr = base_q + (AddrW'(f_q) << PAGE_SHIFT);
    end
  end

endmodule

[rtl/page_frame_pool_manager_unit.sv]
// Top level of the page frame pool manager: configuration, output register, link store.
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+---------------------------------
//  in       | input     | in_valid_i/in_ready_o  | in_word_i: mode, frame_index
//  out      | output    | out_valid_o/out_ready_i| out_word_o: index, addr, status, count
//  cfg      | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
//  Allocate, free and evict pass through the unlink and two append states to the result: the link memories
//  have one write port each, so the unlink and the two append writes go in separate cycles.
//  Failed requests and an evict with a lone busy frame go from the unlink state straight to the result.
//  Rebuild sweeps all MaxFrames entries, one frame a cycle.
//  After reset the lists are empty; no clearing pass runs, the first rebuild clears the marks.
//  A new word is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
module page_frame_pool_manager_unit
  import pfpm_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = DefPageShift
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_word_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [AddrW-1:0] cfg_data_i
);

  logic [AddrW-1:0] pool_start_q, pool_end_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_word_q;
  logic             res_valid;
  logic             res_take;
  rsp_t             res_word;
  mem_cmd_t         mem_cmd;
  mem_rd_t          mem_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= '0;
      pool_end_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_POOL_START) begin
        pool_start_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_POOL_END) begin
        pool_end_q <= cfg_data_i;
      end
    end
  end

  assign res_take    = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  pfpm_ctrl #(
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .pool_start_i(pool_start_q),
    .pool_end_i  (pool_end_q),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res_word),
    .cmd_o       (mem_cmd),
    .rd_i        (mem_rd)
  );

  pfpm_store u_store (
    .clk_i(clk_i),
    .cmd_i(mem_cmd),
    .rd_o (mem_rd)
  );

endmodule
